/* rtl/bqc_pkg.sv */
// Shared types and constants of the low-pass biquad cascade.
// Used by bqc_section, bqc_outstage and biquad_cascade_lowpass; depends on nothing.
package bqc_pkg;

   localparam int INT_BITS       = 24;  // internal section word
   localparam int COEF_BITS      = 18;  // Q2.16 coefficients
   localparam int COEF_FRAC      = 16;
   localparam int PROD_BITS      = COEF_BITS + INT_BITS + 1;
   localparam int ACC_BITS       = 46;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SEC_COUNT_BITS = 2;

   // Register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_SECTION_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LAST_FIRST_ORDER = 3'd1;
   localparam int REG_COEF_BASE    = 2;
   localparam int REGS_PER_SECTION = 3;

   typedef logic signed [INT_BITS-1:0]  value_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;

   localparam value_type VALUE_MAX = {1'b0, {(INT_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(INT_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      COEF_GAIN = 2'd0,
      COEF_FB1  = 2'd1,
      COEF_FB2  = 2'd2
   } coef_sel_type;

   // One request travelling down the chain
   typedef struct packed {
      logic      valid;
      logic      clip;
      value_type value;
   } link_type;

   typedef struct packed {
      logic         we;
      coef_sel_type sel;
      coef_type     data;
   } coef_wr_type;

   typedef struct packed {
      logic active;
      logic first_order;
   } cell_mode_type;

endpackage

/* rtl/biquad_cascade_lowpass.sv */
// Top level of the low-pass biquad cascade: register file, chain of section cells, output cell.
// Depends on bqc_pkg, bqc_section and bqc_outstage.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_sample_in, req_restart
//   rsp      out        rsp_valid/rsp_ready    rsp_sample_out, rsp_clipped
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One request at a time: each active section takes a request from accept to hand-off through
// five products on its single multiplier, accumulate and clamp; an inactive one passes it on.
// req_ready rises again once the result sits in the output register.
// Reset clears histories and coefficients and sets two active sections, second order.
// A stalled rsp holds the result; a finished section then waits in its hold state.
module biquad_cascade_lowpass #(
   parameter int MAX_SECTIONS = 2,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   output logic                                  rsp_clipped,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bqc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bqc_pkg::COEF_BITS-1:0]         csr_data
);
   import bqc_pkg::*;

   localparam int UP = INT_BITS - SAMPLE_BITS;

   logic [SEC_COUNT_BITS-1:0] sec_count_ff;
   logic                      last_first_ff;
   logic                      busy_ff;
   logic [SEC_COUNT_BITS-1:0] nsec;
   logic                      csr_wr;
   logic                      req_acc;
   value_type                 x_in;

   link_type                  link [MAX_SECTIONS+1];
   logic [MAX_SECTIONS:0]     chain_ready;
   logic [MAX_SECTIONS-1:0]   chain_valid;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_ready = !busy_ff && chain_ready[0];
   assign req_acc   = req_valid && req_ready;
   assign x_in      = INT_BITS'(req_sample_in) <<< UP;

   assign link[0].valid = req_valid && !busy_ff;
   assign link[0].clip  = 1'b0;
   assign link[0].value = x_in;

   // Clamp the section count to one..MAX_SECTIONS
   always_comb begin
      if (sec_count_ff == '0) begin
         nsec = SEC_COUNT_BITS'(1);
      end else if (sec_count_ff > SEC_COUNT_BITS'(MAX_SECTIONS)) begin
         nsec = SEC_COUNT_BITS'(MAX_SECTIONS);
      end else begin
         nsec = sec_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_count_ff  <= SEC_COUNT_BITS'(2);
         last_first_ff <= 1'b0;
      end else if (csr_wr) begin
         if (csr_index == REG_SECTION_COUNT) begin
            sec_count_ff <= csr_data[SEC_COUNT_BITS-1:0];
         end
         if (csr_index == REG_LAST_FIRST_ORDER) begin
            last_first_ff <= csr_data[0];
         end
      end
   end

   // Busy from acceptance until the result enters the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_acc) begin
         busy_ff <= 1'b1;
      end else if (link[MAX_SECTIONS].valid && chain_ready[MAX_SECTIONS]) begin
         busy_ff <= 1'b0;
      end
   end

   for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_sec
      localparam int BASE = REG_COEF_BASE + REGS_PER_SECTION * i;
      coef_wr_type   wr;
      cell_mode_type mode;

      always_comb begin
         wr.data = csr_data;
         wr.we   = 1'b0;
         wr.sel  = COEF_GAIN;
         if (csr_wr) begin
            if (csr_index == CSR_INDEX_BITS'(BASE)) begin
               wr.we  = 1'b1;
               wr.sel = COEF_GAIN;
            end else if (csr_index == CSR_INDEX_BITS'(BASE + 1)) begin
               wr.we  = 1'b1;
               wr.sel = COEF_FB1;
            end else if (csr_index == CSR_INDEX_BITS'(BASE + 2)) begin
               wr.we  = 1'b1;
               wr.sel = COEF_FB2;
            end
         end
      end

      assign mode.active      = SEC_COUNT_BITS'(i) < nsec;
      assign mode.first_order = last_first_ff && (SEC_COUNT_BITS'(i) == nsec - 1'b1);
      assign chain_valid[i]   = link[i+1].valid;

      bqc_section u_sec (
         .clock     (clock),
         .reset     (reset),
         .cfg_wr    (wr),
         .mode      (mode),
         .clr       (req_acc && req_restart),
         .in_link   (link[i]),
         .in_ready  (chain_ready[i]),
         .out_link  (link[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   bqc_outstage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out (
      .clock          (clock),
      .reset          (reset),
      .in_link        (link[MAX_SECTIONS]),
      .in_ready       (chain_ready[MAX_SECTIONS]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

   a_one_in_chain: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one request in the section chain");

   a_chain_end_busy: assert property (@(posedge clock) disable iff (reset)
      link[MAX_SECTIONS].valid |-> busy_ff)
      else $error("result at chain end without a request in flight");

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(busy_ff))
      else $error("response raised with no request in flight");

endmodule

/* rtl/bqc_section.sv */
// One direct-form-I biquad section cell: coefficients, histories and one shared multiplier.
// Depends on bqc_pkg.
module bqc_section (
   input  logic                   clock,
   input  logic                   reset,
   input  bqc_pkg::coef_wr_type   cfg_wr,
   input  bqc_pkg::cell_mode_type mode,
   input  logic                   clr,
   input  bqc_pkg::link_type      in_link,
   output logic                   in_ready,
   output bqc_pkg::link_type      out_link,
   input  logic                   out_ready
);
   import bqc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINAL,
      ST_HOLD
   } state_type;

   localparam logic [2:0] STEP_X0 = 3'd0;
   localparam logic [2:0] STEP_X1 = 3'd1;
   localparam logic [2:0] STEP_X2 = 3'd2;
   localparam logic [2:0] STEP_Y1 = 3'd3;
   localparam logic [2:0] STEP_Y2 = 3'd4;

   localparam logic signed [ACC_BITS-1:0] ROUND_INIT = ACC_BITS'(1) <<< (COEF_FRAC - 1);

   state_type                    state_ff;
   logic [2:0]                   step_ff;
   value_type                    x0_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   coef_type                     g_ff, a1_ff, a2_ff;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                         prod_sub_ff, sub_in;
   logic                         clip_ff, first_ff;
   link_type                     out_ff;

   coef_type                     opa;
   logic signed [INT_BITS:0]     opb;
   logic [ACC_BITS-INT_BITS-COEF_FRAC:0] acc_top;
   logic                         ovf;
   value_type                    y_sat;

   // Operand select for the current product
   always_comb begin
      opa    = '0;
      opb    = '0;
      sub_in = 1'b0;
      unique case (step_ff)
         STEP_X0: begin
            opa = g_ff;
            opb = (INT_BITS+1)'(x0_ff);
         end
         STEP_X1: begin
            opa = g_ff;
            opb = first_ff ? (INT_BITS+1)'(x1_ff) : {x1_ff, 1'b0};
         end
         STEP_X2: begin
            opa = g_ff;
            opb = first_ff ? '0 : (INT_BITS+1)'(x2_ff);
         end
         STEP_Y1: begin
            opa    = a1_ff;
            opb    = (INT_BITS+1)'(y1_ff);
            sub_in = 1'b1;
         end
         STEP_Y2: begin
            opa    = a2_ff;
            opb    = first_ff ? '0 : (INT_BITS+1)'(y2_ff);
            sub_in = 1'b1;
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   assign prod_in = opa * opb;
   assign acc_in  = prod_sub_ff ? acc_ff - ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);

   // Drop the fraction, then clamp to the internal word
   assign acc_top = acc_ff[ACC_BITS-1:INT_BITS+COEF_FRAC-1];
   assign ovf     = !((&acc_top) || !(|acc_top));
   assign y_sat   = ovf ? (acc_ff[ACC_BITS-1] ? VALUE_MIN : VALUE_MAX)
                        : acc_ff[INT_BITS+COEF_FRAC-1:COEF_FRAC];

   assign in_ready = (state_ff == ST_IDLE);
   assign out_link = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_ff.valid <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_link.valid) begin
                  if (mode.active) begin
                     x0_ff    <= in_link.value;
                     clip_ff  <= in_link.clip;
                     first_ff <= mode.first_order;
                     step_ff  <= STEP_X0;
                     acc_ff   <= ROUND_INIT;
                     state_ff <= ST_MAC;
                  end else begin
                     // inactive section: pass the request through untouched
                     out_ff   <= in_link;
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_MAC: begin
               prod_ff     <= prod_in;
               prod_sub_ff <= sub_in;
               if (step_ff != STEP_X0) begin
                  acc_ff <= acc_in;
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_Y2) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               acc_ff   <= acc_in;
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               out_ff.valid <= 1'b1;
               out_ff.clip  <= clip_ff | ovf;
               out_ff.value <= y_sat;
               state_ff     <= ST_HOLD;
            end
            ST_HOLD: begin
               if (out_ready) begin
                  out_ff.valid <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Histories: restart clears, a finished sample shifts them
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (state_ff == ST_FINAL) begin
         x2_ff <= x1_ff;
         x1_ff <= x0_ff;
         y2_ff <= y1_ff;
         y1_ff <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff  <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (cfg_wr.we) begin
         unique case (cfg_wr.sel)
            COEF_GAIN: g_ff  <= cfg_wr.data;
            COEF_FB1:  a1_ff <= cfg_wr.data;
            COEF_FB2:  a2_ff <= cfg_wr.data;
            default:   g_ff  <= g_ff;
         endcase
      end
   end

endmodule

/* rtl/bqc_outstage.sv */
// Output cell: rounds the internal word back to sample width, saturates, holds the response.
// Depends on bqc_pkg.
module bqc_outstage #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bqc_pkg::link_type             in_link,
   output logic                          in_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_clipped
);
   import bqc_pkg::*;

   localparam int UP = INT_BITS - SAMPLE_BITS;
   localparam logic signed [INT_BITS:0] RND =
      (UP > 0) ? ((INT_BITS+1)'(1) <<< (UP - 1)) : (INT_BITS+1)'(0);

   logic signed [INT_BITS:0]      sum;
   logic [SAMPLE_BITS:0]          shifted;
   logic                          ovf;
   logic [SAMPLE_BITS-1:0]        sat_val;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          clip_ff;

   assign sum     = (INT_BITS+1)'(in_link.value) + RND;
   assign shifted = sum[INT_BITS:UP];
   assign ovf     = shifted[SAMPLE_BITS] != shifted[SAMPLE_BITS-1];
   assign sat_val = ovf ? {shifted[SAMPLE_BITS], {(SAMPLE_BITS-1){!shifted[SAMPLE_BITS]}}}
                        : shifted[SAMPLE_BITS-1:0];

   assign in_ready       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_clipped    = clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_link.valid && in_ready) begin
         rsp_valid_ff <= 1'b1;
         sample_ff    <= sat_val;
         clip_ff      <= in_link.clip | ovf;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

/* sim/tb_top.sv */
// Self-checking bench for biquad_cascade_lowpass: directed table, then random phases
// with varied coefficients and idling. Depends on bqc_pkg and the RTL top only.
module tb_top;
   import bqc_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SECS    = 2;
   localparam int UP_SHIFT    = INT_BITS - SAMPLE_BITS;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 167;
   localparam int TAIL_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN0 =
      CSR_INDEX_BITS'(REG_COEF_BASE + COEF_GAIN);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FB1_0 =
      CSR_INDEX_BITS'(REG_COEF_BASE + COEF_FB1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FB2_0 =
      CSR_INDEX_BITS'(REG_COEF_BASE + COEF_FB2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN1 =
      CSR_INDEX_BITS'(REG_COEF_BASE + REGS_PER_SECTION + COEF_GAIN);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FB1_1 =
      CSR_INDEX_BITS'(REG_COEF_BASE + REGS_PER_SECTION + COEF_FB1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FB2_1 =
      CSR_INDEX_BITS'(REG_COEF_BASE + REGS_PER_SECTION + COEF_FB2);

   localparam coef_type COEF_MAX = 18'sh1FFFF;
   localparam coef_type COEF_MIN = 18'sh20000;
   localparam coef_type COEF_ONE = 18'sh10000;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          clip;
   } filt_result_type;

   typedef struct {
      row_kind_type                  kind;
      logic [CSR_INDEX_BITS-1:0]     idx;
      logic [COEF_BITS-1:0]          data;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic                          rst;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] k_out;
      logic                          k_clip;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_clipped;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [COEF_BITS-1:0]          csr_data = '0;

   // typed-in expectation travels with the request like payload
   logic                          pin_en = 1'b0;
   logic signed [SAMPLE_BITS-1:0] pin_out = '0;
   logic                          pin_clip = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   filt_result_type pending_results[$];

   // filter image: configuration and per-section histories
   logic [1:0] active_secs;
   logic       last_first;
   coef_type   gain_c[MAX_SECS];
   coef_type   fb1_c[MAX_SECS];
   coef_type   fb2_c[MAX_SECS];
   value_type  xh1[MAX_SECS];
   value_type  xh2[MAX_SECS];
   value_type  yh1[MAX_SECS];
   value_type  yh2[MAX_SECS];

   biquad_cascade_lowpass #(.MAX_SECTIONS(MAX_SECS), .SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_in(req_sample_in), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out), .rsp_clipped(rsp_clipped),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_history();
      for (int s = 0; s < MAX_SECS; s++) begin
         xh1[s] = '0;
         xh2[s] = '0;
         yh1[s] = '0;
         yh2[s] = '0;
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [COEF_BITS-1:0] data);
      int rel;
      int sec;
      rel = int'(idx) - REG_COEF_BASE;
      sec = rel / REGS_PER_SECTION;
      if (idx == REG_SECTION_COUNT) begin
         active_secs = data[1:0];
      end else if (idx == REG_LAST_FIRST_ORDER) begin
         last_first = data[0];
      end else if (rel >= 0 && sec < MAX_SECS) begin
         case (coef_sel_type'(rel % REGS_PER_SECTION))
            COEF_GAIN: gain_c[sec] = data;
            COEF_FB1:  fb1_c[sec] = data;
            default:   fb2_c[sec] = data;
         endcase
      end
   endfunction

   function automatic void filter_predict(input logic signed [SAMPLE_BITS-1:0] smp,
                                          input logic rst, output filt_result_type res);
      longint x;
      longint acc;
      longint g;
      int     n;
      logic   clip;
      clip = 1'b0;
      if (rst) clear_history();
      n = (active_secs == 0) ? 1 : (active_secs > MAX_SECS) ? MAX_SECS : int'(active_secs);
      x = longint'(smp) * (longint'(1) << UP_SHIFT);
      for (int s = 0; s < n; s++) begin
         g = gain_c[s];
         if (s == n - 1 && last_first) begin
            acc = g * x + g * xh1[s] - longint'(fb1_c[s]) * yh1[s];
         end else begin
            acc = g * x + 2 * g * xh1[s] + g * xh2[s]
                  - longint'(fb1_c[s]) * yh1[s] - longint'(fb2_c[s]) * yh2[s];
         end
         acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
         if (acc > longint'(VALUE_MAX)) begin
            acc = VALUE_MAX;
            clip = 1'b1;
         end else if (acc < longint'(VALUE_MIN)) begin
            acc = VALUE_MIN;
            clip = 1'b1;
         end
         xh2[s] = xh1[s];
         xh1[s] = value_type'(x);
         yh2[s] = yh1[s];
         yh1[s] = value_type'(acc);
         x = acc;
      end
      x = (x + (longint'(1) << (UP_SHIFT - 1))) >>> UP_SHIFT;
      if (x > longint'(SAMPLE_MAX)) begin
         x = SAMPLE_MAX;
         clip = 1'b1;
      end else if (x < longint'(SAMPLE_MIN)) begin
         x = SAMPLE_MIN;
         clip = 1'b1;
      end
      res.value = SAMPLE_BITS'(x);
      res.clip = clip;
   endfunction

   // Score every handshake at the edge where it completes
   always @(posedge clock) begin
      filt_result_type want;
      filt_result_type got_pred;
      if (reset) begin
         active_secs = 2'd2;
         last_first = 1'b0;
         for (int s = 0; s < MAX_SECS; s++) begin
            gain_c[s] = '0;
            fb1_c[s] = '0;
            fb2_c[s] = '0;
         end
         clear_history();
      end else begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result %0d clipped %0b with none expected",
                        $time, rsp_sample_out, rsp_clipped);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_sample_out !== want.value) begin
                  $display("%0t: sample_out expected %0d got %0d",
                           $time, want.value, rsp_sample_out);
                  error_count++;
               end
               if (rsp_clipped !== want.clip) begin
                  $display("%0t: clipped expected %0b got %0b",
                           $time, want.clip, rsp_clipped);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            filter_predict(req_sample_in, req_restart, got_pred);
            if (pin_en) begin
               got_pred.value = pin_out;
               got_pred.clip = pin_clip;
            end
            pending_results.push_back(got_pred);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic signed [SAMPLE_BITS-1:0] smp, input logic rst,
                               input logic known, input logic signed [SAMPLE_BITS-1:0] k_out,
                               input logic k_clip);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_restart <= rst;
      pin_en <= known;
      pin_out <= k_out;
      pin_clip <= k_clip;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Hold off new requests until every expected result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic plan_row_type row_req(input logic signed [SAMPLE_BITS-1:0] smp,
                                            input logic rst, input logic known,
                                            input logic signed [SAMPLE_BITS-1:0] k_out,
                                            input logic k_clip);
      plan_row_type r;
      r = '{ROW_REQ, '0, '0, smp, rst, known, k_out, k_clip};
      return r;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                            input logic [COEF_BITS-1:0] data);
      plan_row_type r;
      r = '{ROW_CSR, idx, data, '0, 1'b0, 1'b0, '0, 1'b0};
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2:    return SAMPLE_BITS'(int'($urandom_range(0, 400)) - 200);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // style 0: plausible low-pass values, 1: anything, 2: corners
   function automatic coef_type coef_value(input int style, input coef_sel_type kind);
      if (style == 0) begin
         case (kind)
            COEF_GAIN: return coef_type'($urandom_range(64, 12000));
            COEF_FB1:  return coef_type'(-int'($urandom_range(30000, 125000)));
            default:   return coef_type'($urandom_range(5000, 60000));
         endcase
      end else if (style == 1) begin
         return coef_type'($urandom);
      end
      case ($urandom_range(0, 3))
         0:       return COEF_MIN;
         1:       return COEF_MAX;
         2:       return '0;
         default: return COEF_ONE;
      endcase
   endfunction

   task automatic program_filter(input int p);
      int style;
      style = p % 3;
      write_reg(REG_SECTION_COUNT, {16'($urandom), 2'(p % 4)});
      write_reg(REG_LAST_FIRST_ORDER, {17'($urandom), 1'((p / 2) % 2)});
      for (int s = 0; s < MAX_SECS; s++) begin
         write_reg(CSR_INDEX_BITS'(REG_COEF_BASE + s * REGS_PER_SECTION + COEF_GAIN),
                   coef_value(style, COEF_GAIN));
         write_reg(CSR_INDEX_BITS'(REG_COEF_BASE + s * REGS_PER_SECTION + COEF_FB1),
                   coef_value(style, COEF_FB1));
         write_reg(CSR_INDEX_BITS'(REG_COEF_BASE + s * REGS_PER_SECTION + COEF_FB2),
                   coef_value(style, COEF_FB2));
      end
   endtask

   initial begin
      plan_row_type plan[$];
      int mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         // zero coefficients after reset
         row_req(SAMPLE_MAX, 1'b0, 1'b1, 16'sd0, 1'b0),
         row_req(SAMPLE_MIN, 1'b0, 1'b1, 16'sd0, 1'b0),
         row_req(16'sd0, 1'b1, 1'b1, 16'sd0, 1'b0),
         // full-scale gain drives both sections into the rails
         row_csr(REG_GAIN0, COEF_MAX),
         row_csr(REG_GAIN1, COEF_MAX),
         row_req(SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, 1'b1),
         row_req(SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN, 1'b1),
         row_req(16'sd1, 1'b0, 1'b0, 16'sd0, 1'b0),
         // count of zero acts as one section, made first order with unity gain
         row_csr(REG_SECTION_COUNT, 18'h3FFFC),
         row_csr(REG_LAST_FIRST_ORDER, 18'h00001),
         row_csr(REG_GAIN0, COEF_ONE),
         row_req(16'sd12345, 1'b1, 1'b1, 16'sd12345, 1'b0),
         row_req(-16'sd12345, 1'b0, 1'b1, 16'sd0, 1'b0),
         row_req(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN, 1'b1),
         row_csr(REG_FB1_0, COEF_MIN),
         row_csr(REG_FB2_0, COEF_MAX),
         row_req(-16'sd1, 1'b0, 1'b0, 16'sd0, 1'b0),
         row_req(SAMPLE_MAX, 1'b0, 1'b0, 16'sd0, 1'b0),
         // count above the maximum acts as two sections
         row_csr(REG_SECTION_COUNT, 18'h00003),
         row_csr(REG_FB1_1, COEF_MAX),
         row_csr(REG_FB2_1, COEF_MIN),
         row_req(16'sd100, 1'b1, 1'b0, 16'sd0, 1'b0),
         row_req(-16'sd100, 1'b0, 1'b0, 16'sd0, 1'b0),
         row_csr(REG_LAST_FIRST_ORDER, 18'h00000),
         row_req(16'sd7, 1'b0, 1'b0, 16'sd0, 1'b0),
         row_req(16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0)
      };

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_results();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_request(plan[i].smp, plan[i].rst, plan[i].known,
                         plan[i].k_out, plan[i].k_clip);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         program_filter(p);
         mode = (p / 3) % 4;
         send_idle_pct = (mode == 1) ? 61 : (mode == 3) ? 18 : 0;
         recv_stall_pct <= (mode == 2) ? 61 : (mode == 3) ? 18 : 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 5 && k == PHASE_ITEMS / 2) drain_results();
            send_request(pick_sample(), $urandom_range(0, 31) == 0, 1'b0, 16'sd0, 1'b0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results expected, 0 arrived", $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
rtl/bqc_pkg.sv
rtl/bqc_section.sv
rtl/bqc_outstage.sv
rtl/biquad_cascade_lowpass.sv
sim/tb_top.sv
